@@ rtl/lfu_pkg.sv @@
// lfu_pkg: shared widths, codes and control structs for the lfu cache block
// depends on nothing; imported by every rtl file of the block
package lfu_pkg;

	// field widths
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 48;

	// default slot count
	localparam int ENTRIES_DEF = 16;

	// register reset and saturation limits
	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;
	localparam logic [VAL_W-1:0]   MISS_VALUE = '1;

	// operation codes
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// request control into the slot array
	typedef struct packed {
		logic fire;      // item completes this cycle, commit updates
		logic put;       // put request
		logic ins_ok;    // capacity is nonzero
		logic evict_ok;  // occupancy has reached capacity
	} lfu_req_t;

	// status back from the slot array
	typedef struct packed {
		logic hit;       // key was present
		logic stamped;   // a slot takes the next tick
		logic inserted;  // a new entry is written
		logic evicted;   // a victim is dropped
	} lfu_stat_t;

endpackage

@@ rtl/lfu_victim.sv @@
// lfu_victim: min-select tree picking the slot with lowest count, then oldest stamp
// depends on lfu_pkg; instantiated by lfu_slots
module lfu_victim #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
	parameter int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic [ENTRIES-1:0]            valid,
	input  logic [lfu_pkg::CNT_W-1:0]     cnt   [ENTRIES],
	input  logic [lfu_pkg::STAMP_W-1:0]   stamp [ENTRIES],
	output logic                          found,
	output logic [IDXW-1:0]               idx
);
	import lfu_pkg::*;

	localparam int LEAVES = 1 << IDXW;
	localparam int NODES  = 2 * LEAVES - 1;

	typedef struct packed {
		logic               v;
		logic [CNT_W-1:0]   cnt;
		logic [STAMP_W-1:0] stamp;
		logic [IDXW-1:0]    idx;
	} node_t;

	node_t node [NODES];

	// leaves in slot order, padding leaves never win
	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < ENTRIES) begin : g_real
			assign node[LEAVES-1+i] = '{v: valid[i], cnt: cnt[i], stamp: stamp[i],
				idx: IDXW'(i)};
		end else begin : g_pad
			assign node[LEAVES-1+i] = '{v: 1'b0, cnt: '0, stamp: '0, idx: IDXW'(i)};
		end
	end

	// left child holds lower slots, so the right one wins only when strictly better
	for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
		logic take_r;
		assign take_r = node[2*n+2].v && (!node[2*n+1].v ||
			(node[2*n+2].cnt < node[2*n+1].cnt) ||
			((node[2*n+2].cnt == node[2*n+1].cnt) &&
			 (node[2*n+2].stamp < node[2*n+1].stamp)));
		assign node[n] = take_r ? node[2*n+2] : node[2*n+1];
	end

	assign found = node[0].v;
	assign idx   = node[0].idx;

endmodule

@@ rtl/lfu_slots.sv @@
// lfu_slots: slot array with key match, victim and free-slot choice and updates
// depends on lfu_pkg and lfu_victim; instantiated by the top level
module lfu_slots #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfu_pkg::lfu_req_t             req,
	input  logic [lfu_pkg::KEY_W-1:0]     req_key,
	input  logic [lfu_pkg::VAL_W-1:0]     req_value,
	input  logic [lfu_pkg::STAMP_W-1:0]   req_stamp,
	output lfu_pkg::lfu_stat_t            stat,
	output logic [lfu_pkg::VAL_W-1:0]     hit_value
);
	import lfu_pkg::*;

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q   [ENTRIES];
	logic [VAL_W-1:0]   val_q   [ENTRIES];
	logic [CNT_W-1:0]   cnt_q   [ENTRIES];
	logic [STAMP_W-1:0] stamp_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] vict_oh;
	logic [ENTRIES-1:0] evict_oh;
	logic [ENTRIES-1:0] free_mask;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] ins_oh;
	logic               vict_found;
	logic [IDXW-1:0]    vict_idx;
	logic               hit_any;
	logic               do_ins;
	logic               do_evict;
	logic               bump;

	// lowest count, oldest stamp among valid slots
	lfu_victim #(
		.ENTRIES (ENTRIES),
		.IDXW    (IDXW)
	) u_victim (
		.valid (valid_q),
		.cnt   (cnt_q),
		.stamp (stamp_q),
		.found (vict_found),
		.idx   (vict_idx)
	);

	// parallel key compare and victim decode
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]   = valid_q[i] && (key_q[i] == req_key);
			vict_oh[i] = vict_found && (vict_idx == IDXW'(i));
		end
	end

	// keys are unique, so and-or of the matching slot gives its value
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_value = hit_value | val_q[i];
			end
		end
	end

	// decide the action for this item
	always_comb begin
		hit_any   = |match;
		bump      = hit_any && (!req.put || req.ins_ok);
		do_ins    = req.put && req.ins_ok && !hit_any;
		do_evict  = do_ins && req.evict_ok && vict_found;
		evict_oh  = do_evict ? vict_oh : '0;
		// the freed victim counts as free when picking the lowest open slot
		free_mask = ~valid_q | evict_oh;
		free_oh   = free_mask & (~free_mask + ENTRIES'(1));
		ins_oh    = do_ins ? free_oh : '0;

		stat.hit      = hit_any;
		stat.inserted = do_ins && (|free_mask);
		stat.evicted  = do_evict;
		stat.stamped  = bump || stat.inserted;
	end

	// valid bits: evict then insert, insert wins when both hit one slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.fire) begin
			valid_q <= (valid_q & ~evict_oh) | ins_oh;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (req.fire && ins_oh[i]) begin
				key_q[i]   <= req_key;
				val_q[i]   <= req_value;
				cnt_q[i]   <= CNT_W'(1);
				stamp_q[i] <= req_stamp;
			end else if (req.fire && bump && match[i]) begin
				if (cnt_q[i] != CNT_MAX) begin
					cnt_q[i] <= cnt_q[i] + CNT_W'(1);
				end
				stamp_q[i] <= req_stamp;
				if (req.put) begin
					val_q[i] <= req_value;
				end
			end
		end
	end

endmodule

@@ rtl/lfu_cache_lru_tiebreak_top.sv @@
// lfu_cache_lru_tiebreak_top: lfu key/value cache with lru tie-break, top level
// depends on lfu_pkg and lfu_slots
//
//   channel   signals                                  direction
//   cfg       cfg_valid cfg_ready cfg_data             in  (capacity_in_use)
//   in        in_valid in_ready func lookup_key        in
//             write_value
//   out       out_valid out_ready hit read_value       out
//
// an item is held in the input register, then the lookup, victim tree and slot
// update finish combinationally into the result register; one item per cycle is
// sustained while no result waits with out_ready low.
// the input register stalls only while a result waits and out_ready is low.
// reset clears valid bits, tick, occupancy and sets capacity to 16; no clearing pass.
// cfg_ready is always high.
module lfu_cache_lru_tiebreak_top #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value
);
	import lfu_pkg::*;

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [CAP_W-1:0]   capacity_q;
	logic [OCC_W-1:0]   occ_q;
	logic [STAMP_W-1:0] tick_q;
	logic [STAMP_W-1:0] tick_next;

	logic               v_s1;
	logic               func_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [VAL_W-1:0]   val_s1;

	logic               out_valid_q;
	logic               hit_q;
	logic [VAL_W-1:0]   rdata_q;

	logic               adv;
	logic [CW-1:0]      cap_ext;
	logic [CW-1:0]      ent_ext;
	logic [CW-1:0]      cap_eff;
	logic [CW-1:0]      occ_ext;
	lfu_req_t           req;
	lfu_stat_t          stat;
	logic [VAL_W-1:0]   hit_value;
	logic [VAL_W-1:0]   rdata_d;

	// handshakes
	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !v_s1 || adv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			key_s1  <= $unsigned(lookup_key);
			val_s1  <= $unsigned(write_value);
		end
	end

	// effective capacity and eviction need
	always_comb begin
		cap_ext = CW'(capacity_q);
		ent_ext = CW'(ENTRIES);
		cap_eff = (cap_ext > ent_ext) ? ent_ext : cap_ext;
		occ_ext = CW'(occ_q);

		req.fire     = adv;
		req.put      = (func_s1 == FUNC_PUT);
		req.ins_ok   = (cap_eff != '0);
		req.evict_ok = (occ_ext >= cap_eff);
	end

	// saturating recency tick
	assign tick_next = (tick_q == STAMP_MAX) ? tick_q : tick_q + STAMP_W'(1);

	lfu_slots #(
		.ENTRIES (ENTRIES)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_key   (key_s1),
		.req_value (val_s1),
		.req_stamp (tick_next),
		.stat      (stat),
		.hit_value (hit_value)
	);

	// tick and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			occ_q  <= '0;
		end else if (adv) begin
			if (stat.stamped) begin
				tick_q <= tick_next;
			end
			if (stat.inserted && !stat.evicted && (occ_q != OCC_W'(ENTRIES))) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (stat.evicted && !stat.inserted && (occ_q != '0)) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	// result value: zero for put, stored value or miss marker for get
	always_comb begin
		if (req.put) begin
			rdata_d = '0;
		end else if (stat.hit) begin
			rdata_d = hit_value;
		end else begin
			rdata_d = MISS_VALUE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= stat.hit && (!req.put || req.ins_ok);
			rdata_q <= rdata_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = $signed(rdata_q);

endmodule

@@ rtl/lfu_checker.sv @@
// lfu_checker: port-level assertions for the lfu cache top level
// depends on lfu_pkg widths; bound to lfu_cache_lru_tiebreak_top
module lfu_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [lfu_pkg::CAP_W-1:0]         cfg_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              func,
	input logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
	input logic signed [lfu_pkg::VAL_W-1:0]  write_value,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              hit,
	input logic signed [lfu_pkg::VAL_W-1:0]  read_value
);
	import lfu_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value))
		else $error("result changed while stalled");

	// a miss reports zero for put or the miss marker for get
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (read_value == '0) || (read_value == MISS_VALUE))
		else $error("miss result carries a stored value");

	// input back-pressure only comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// a fresh result traces to an accepted item, via the input and result registers
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted item");

endmodule

bind lfu_cache_lru_tiebreak_top lfu_checker u_lfu_checker (.*);
